@@ design/kor_pkg.sv @@
// Shared widths, register indexes and point codes for the keep-out corner detour router.
`timescale 1ns / 1ps
package kor_pkg;

  // Field and datapath widths
  localparam int CRD_W   = 31;  // signed coordinate
  localparam int REG_W   = 30;  // configuration register
  localparam int BND_W   = 33;  // zone bound and raw waypoint, signed
  localparam int MUL_W   = 34;  // multiplier operand, signed
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SQ_W    = 64;  // radicand and root working width
  localparam int LEN_W   = 32;  // one leg length
  localparam int SUM_W   = 34;  // route length, up to three legs
  localparam int TDATA_W = 64;  // two coordinates, padded to bytes
  localparam int CFG_IDX_W = 3;

  localparam int DEF_UNITS_PER_MM = 1000000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTCH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 3'd4;

  // Segment end point codes
  localparam logic [1:0] PT_A  = 2'd0;  // previous point
  localparam logic [1:0] PT_B  = 2'd1;  // current point
  localparam logic [1:0] PT_W0 = 2'd2;  // left inner-corner waypoint
  localparam logic [1:0] PT_W1 = 2'd3;  // right inner-corner waypoint

  // Coordinate range limits at bound width
  localparam logic signed [BND_W-1:0] CRD_MAX_B = 33'sd1073741823;
  localparam logic signed [BND_W-1:0] CRD_MIN_B = -33'sd1073741824;

endpackage

@@ design/keep_out_corner_detour_router.sv @@
// Top level: segment check against two corner keep-out zones and detour through waypoints.
`timescale 1ns / 1ps
// Pass-through points (new polyline, disabled, clear segment, escape move) go straight to
//   the emit state; a detour first measures five legs and then weighs four candidate routes.
// Throughput: one point at a time; ready is low until its last result is registered.
//   The time is set by one shared 34x34 multiplier pair (Liang-Barsky cross products,
//   14 zone and segment tests) and a one-bit-pair-a-cycle root.
// Reset: asynchronous, active low; clears previous point and loads default registers.
module keep_out_corner_detour_router #(
  parameter int UNITS_PER_MM = kor_pkg::DEF_UNITS_PER_MM
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input points
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [kor_pkg::TDATA_W-1:0] s_axis_tdata,   // point_x, point_y
  input  logic [0:0]                  s_axis_tuser,   // first_point
  // results
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [kor_pkg::TDATA_W-1:0] m_axis_tdata,   // out_x, out_y
  output logic [1:0]                  m_axis_tuser,   // is_waypoint, blocked
  output logic                        m_axis_tlast,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [kor_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kor_pkg::REG_W-1:0]     cfg_data_i
);
  import kor_pkg::*;

  localparam logic [REG_W-1:0] NOTCH_RST  = REG_W'(40 * UNITS_PER_MM);
  localparam logic [REG_W-1:0] BED_RST    = REG_W'(350 * UNITS_PER_MM);
  localparam logic [REG_W-1:0] CLEAR_RST  = REG_W'(UNITS_PER_MM);
  localparam logic [REG_W-1:0] MARGIN_RST = REG_W'(UNITS_PER_MM / 20);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_EDGE   = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_CMP    = 4'd3;
  localparam logic [3:0] ST_SQMUL  = 4'd4;
  localparam logic [3:0] ST_SQLOAD = 4'd5;
  localparam logic [3:0] ST_SQRUN  = 4'd6;
  localparam logic [3:0] ST_CAND   = 4'd7;
  localparam logic [3:0] ST_EMIT   = 4'd8;

  localparam logic [SQ_W-1:0] SQ_BIT_TOP = SQ_W'(1) << (SQ_W - 2);

  function automatic logic signed [CRD_W-1:0] clamp_crd(input logic signed [BND_W-1:0] v);
    if (v > CRD_MAX_B)      return CRD_W'(CRD_MAX_B);
    else if (v < CRD_MIN_B) return CRD_W'(CRD_MIN_B);
    else                    return v[CRD_W-1:0];
  endfunction

  // Configuration registers
  logic             enable_q;
  logic [REG_W-1:0] notch_q, bed_q, clear_q, margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      notch_q  <= NOTCH_RST;
      bed_q    <= BED_RST;
      clear_q  <= CLEAR_RST;
      margin_q <= MARGIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE: enable_q <= cfg_data_i[0];
        CFG_NOTCH:  notch_q  <= cfg_data_i;
        CFG_BED:    bed_q    <= cfg_data_i;
        CFG_CLEAR:  clear_q  <= cfg_data_i;
        CFG_MARGIN: margin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zone bounds and waypoints from the registers
  logic signed [BND_W-1:0] n_b, w_b, c_b, m_b;
  logic signed [BND_W-1:0] zy0, zy1, z0x0, z0x1, z1x0, z1x1, wr0, wr1;
  logic signed [CRD_W-1:0] wx0, wx1;

  assign n_b  = {3'b000, notch_q};
  assign w_b  = {3'b000, bed_q};
  assign c_b  = {3'b000, clear_q};
  assign m_b  = {3'b000, margin_q};
  assign zy0  = -c_b;
  assign zy1  = n_b + c_b;
  assign z0x0 = -c_b;
  assign z0x1 = n_b + c_b;
  assign z1x0 = w_b - n_b - c_b;
  assign z1x1 = w_b + c_b;
  assign wr0  = n_b + c_b + m_b;
  assign wr1  = w_b - n_b - c_b - m_b;
  assign wx0  = clamp_crd(wr0);   // also the y of both waypoints
  assign wx1  = clamp_crd(wr1);

  // Sequencer and datapath registers
  logic [3:0]              state_q, state_d;
  logic signed [CRD_W-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic                    have_prev_q, have_prev_d;
  logic signed [CRD_W-1:0] ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic [2:0]              s_q, s_d, l_q, l_d;
  logic                    box_q, box_d, fin_q, fin_d, phase_q, phase_d, ent_q, ent_d;
  logic [1:0]              e_q, e_d;
  logic signed [MUL_W-1:0] t0n_q, t0n_d, t0d_q, t0d_d, t1n_q, t1n_d, t1d_q, t1d_d;
  logic signed [MUL_W-1:0] rn_q, rn_d, rd_q, rd_d;
  logic signed [PROD_W-1:0] pa_q, pa_d, pb_q, pb_d;
  logic [6:0]              segclr_q, segclr_d;
  logic [SQ_W-1:0]         v_q, v_d, r_q, r_d, bit_q, bit_d;
  logic [LEN_W-1:0]        len_q [5];
  logic [LEN_W-1:0]        len_d [5];
  logic [1:0]              cand_q, cand_d, rcnt_q, rcnt_d, k_q, k_d;
  logic                    found_q, found_d, r0_q, r0_d, blk_q, blk_d;
  logic [SUM_W-1:0]        best_q, best_d;
  logic                    m_valid_q, m_valid_d, m_wp_q, m_wp_d, m_blk_q, m_blk_d;
  logic                    m_last_q, m_last_d;
  logic signed [CRD_W-1:0] m_x_q, m_x_d, m_y_q, m_y_d;

  // Segment end points: tested segment, or the leg being measured
  logic [1:0] p_code, q_code;
  logic signed [CRD_W-1:0] px, py, qx, qy;

  always_comb begin
    if (state_q == ST_SQMUL) begin
      unique case (l_q)
        3'd0:    begin p_code = PT_A;  q_code = PT_W0; end
        3'd1:    begin p_code = PT_A;  q_code = PT_W1; end
        3'd2:    begin p_code = PT_W0; q_code = PT_B;  end
        3'd3:    begin p_code = PT_W1; q_code = PT_B;  end
        default: begin p_code = PT_W0; q_code = PT_W1; end
      endcase
    end else begin
      unique case (s_q)
        3'd0:    begin p_code = PT_A;  q_code = PT_B;  end
        3'd1:    begin p_code = PT_A;  q_code = PT_W0; end
        3'd2:    begin p_code = PT_A;  q_code = PT_W1; end
        3'd3:    begin p_code = PT_W0; q_code = PT_B;  end
        3'd4:    begin p_code = PT_W1; q_code = PT_B;  end
        3'd5:    begin p_code = PT_W0; q_code = PT_W1; end
        default: begin p_code = PT_W1; q_code = PT_W0; end
      endcase
    end
  end

  always_comb begin
    unique case (p_code)
      PT_A:    begin px = ax_q; py = ay_q; end
      PT_B:    begin px = bx_q; py = by_q; end
      PT_W0:   begin px = wx0;  py = wx0;  end
      default: begin px = wx1;  py = wx0;  end
    endcase
    unique case (q_code)
      PT_A:    begin qx = ax_q; qy = ay_q; end
      PT_B:    begin qx = bx_q; qy = by_q; end
      PT_W0:   begin qx = wx0;  qy = wx0;  end
      default: begin qx = wx1;  qy = wx0;  end
    endcase
  end

  logic signed [CRD_W:0]   dx, dy;
  logic signed [MUL_W-1:0] dx_m, dy_m, px_m, py_m;
  logic signed [MUL_W-1:0] x0_m, x1_m, y0_m, y1_m;

  assign dx   = {qx[CRD_W-1], qx} - {px[CRD_W-1], px};
  assign dy   = {qy[CRD_W-1], qy} - {py[CRD_W-1], py};
  assign dx_m = {{(MUL_W-CRD_W-1){dx[CRD_W]}}, dx};
  assign dy_m = {{(MUL_W-CRD_W-1){dy[CRD_W]}}, dy};
  assign px_m = {{(MUL_W-CRD_W){px[CRD_W-1]}}, px};
  assign py_m = {{(MUL_W-CRD_W){py[CRD_W-1]}}, py};
  assign x0_m = box_q ? {z1x0[BND_W-1], z1x0} : {z0x0[BND_W-1], z0x0};
  assign x1_m = box_q ? {z1x1[BND_W-1], z1x1} : {z0x1[BND_W-1], z0x1};
  assign y0_m = {zy0[BND_W-1], zy0};
  assign y1_m = {zy1[BND_W-1], zy1};

  // Liang-Barsky edge terms for the current edge
  logic signed [MUL_W-1:0] num_e, den_e;

  always_comb begin
    unique case (e_q)
      2'd0:    begin num_e = -dx_m; den_e = px_m - x0_m; end
      2'd1:    begin num_e = dx_m;  den_e = x1_m - px_m; end
      2'd2:    begin num_e = -dy_m; den_e = py_m - y0_m; end
      default: begin num_e = dy_m;  den_e = y1_m - py_m; end
    endcase
  end

  // Shared multiplier pair: cross products, or squares of a leg
  logic signed [MUL_W-1:0] mul_a, mul_b, mul_c, mul_d;
  logic                    sel_t1;

  assign sel_t1 = ent_q ^ phase_q;

  always_comb begin
    if (state_q == ST_SQMUL) begin
      mul_a = dx_m; mul_b = dx_m; mul_c = dy_m; mul_d = dy_m;
    end else if (fin_q) begin
      mul_a = t1n_q; mul_b = t0d_q; mul_c = t0n_q; mul_d = t1d_q;
    end else begin
      mul_a = rn_q;
      mul_b = sel_t1 ? t1d_q : t0d_q;
      mul_c = sel_t1 ? t1n_q : t0n_q;
      mul_d = rd_q;
    end
  end

  assign pa_d = mul_a * mul_b;
  assign pb_d = mul_c * mul_d;

  // Start point strictly inside a zone
  logic signed [BND_W-1:0] ax_b, ay_b;
  logic                    a_inside;

  assign ax_b = {{(BND_W-CRD_W){ax_q[CRD_W-1]}}, ax_q};
  assign ay_b = {{(BND_W-CRD_W){ay_q[CRD_W-1]}}, ay_q};
  assign a_inside = (ay_b > zy0) && (ay_b < zy1) &&
                    (((ax_b > z0x0) && (ax_b < z0x1)) || ((ax_b > z1x0) && (ax_b < z1x1)));

  // Root step
  logic [SQ_W-1:0] sq_t, r_next;
  logic            sq_ge;

  assign sq_t   = r_q + bit_q;
  assign sq_ge  = v_q >= sq_t;
  assign r_next = sq_ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);

  // Candidate route evaluation
  logic             cand_ok, cand_r0;
  logic [1:0]       cand_cnt;
  logic [SUM_W-1:0] cand_sum;

  always_comb begin
    case (cand_q)
      2'd0: begin
        cand_ok  = segclr_q[1] & segclr_q[3];
        cand_sum = SUM_W'(len_q[0]) + SUM_W'(len_q[2]);
        cand_cnt = 2'd1; cand_r0 = 1'b0;
      end
      2'd1: begin
        cand_ok  = segclr_q[2] & segclr_q[4];
        cand_sum = SUM_W'(len_q[1]) + SUM_W'(len_q[3]);
        cand_cnt = 2'd1; cand_r0 = 1'b1;
      end
      2'd2: begin
        cand_ok  = segclr_q[1] & segclr_q[5] & segclr_q[4];
        cand_sum = SUM_W'(len_q[0]) + SUM_W'(len_q[4]) + SUM_W'(len_q[3]);
        cand_cnt = 2'd2; cand_r0 = 1'b0;
      end
      default: begin
        cand_ok  = segclr_q[2] & segclr_q[6] & segclr_q[3];
        cand_sum = SUM_W'(len_q[1]) + SUM_W'(len_q[4]) + SUM_W'(len_q[2]);
        cand_cnt = 2'd2; cand_r0 = 1'b1;
      end
    endcase
  end

  // Sequencer
  logic box_done, box_hit, seg_free, cmp_gt, cmp_lt, cand_take;

  assign cmp_gt = pa_q > pb_q;
  assign cmp_lt = pa_q < pb_q;
  assign cand_take = cand_ok && (!found_q || (cand_sum < best_q));

  always_comb begin
    state_d = state_q;
    prev_x_d = prev_x_q; prev_y_d = prev_y_q; have_prev_d = have_prev_q;
    ax_d = ax_q; ay_d = ay_q; bx_d = bx_q; by_d = by_q;
    s_d = s_q; l_d = l_q; box_d = box_q; fin_d = fin_q; phase_d = phase_q; ent_d = ent_q;
    e_d = e_q;
    t0n_d = t0n_q; t0d_d = t0d_q; t1n_d = t1n_q; t1d_d = t1d_q;
    rn_d = rn_q; rd_d = rd_q;
    segclr_d = segclr_q;
    v_d = v_q; r_d = r_q; bit_d = bit_q;
    len_d = len_q;
    cand_d = cand_q; found_d = found_q; best_d = best_q;
    rcnt_d = rcnt_q; r0_d = r0_q; blk_d = blk_q; k_d = k_q;
    m_x_d = m_x_q; m_y_d = m_y_q; m_wp_d = m_wp_q; m_blk_d = m_blk_q; m_last_d = m_last_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    box_done = 1'b0;
    box_hit  = 1'b0;
    seg_free = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          prev_x_d    = s_axis_tdata[CRD_W-1:0];
          prev_y_d    = s_axis_tdata[2*CRD_W-1:CRD_W];
          have_prev_d = 1'b1;
          ax_d = prev_x_q;
          ay_d = prev_y_q;
          bx_d = s_axis_tdata[CRD_W-1:0];
          by_d = s_axis_tdata[2*CRD_W-1:CRD_W];
          rcnt_d = 2'd0;
          blk_d  = 1'b0;
          k_d    = 2'd0;
          if (s_axis_tuser[0] || !have_prev_q || !enable_q) begin
            state_d = ST_EMIT;
          end else begin
            s_d = 3'd0; box_d = 1'b0; e_d = 2'd0; fin_d = 1'b0;
            t0n_d = '0; t0d_d = MUL_W'(1); t1n_d = MUL_W'(1); t1d_d = MUL_W'(1);
            state_d = ST_EDGE;
          end
        end
      end
      ST_EDGE: begin
        if (num_e == '0) begin
          // parallel to this edge: outside it means no crossing
          if (den_e < 0) begin
            box_done = 1'b1;
          end else if (e_q == 2'd3) begin
            fin_d = 1'b1; state_d = ST_MUL;
          end else begin
            e_d = e_q + 2'd1;
          end
        end else begin
          ent_d   = num_e < 0;
          rn_d    = (num_e < 0) ? -den_e : den_e;
          rd_d    = (num_e < 0) ? -num_e : num_e;
          phase_d = 1'b0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_CMP;
      ST_CMP: begin
        if (fin_q) begin
          box_done = 1'b1;
          box_hit  = cmp_gt;
        end else if (!phase_q) begin
          // reject when the interval is already empty
          if (ent_q ? cmp_gt : cmp_lt) begin
            box_done = 1'b1;
          end else begin
            phase_d = 1'b1; state_d = ST_MUL;
          end
        end else begin
          if (ent_q && cmp_gt) begin
            t0n_d = rn_q; t0d_d = rd_q;
          end else if (!ent_q && cmp_lt) begin
            t1n_d = rn_q; t1d_d = rd_q;
          end
          if (e_q == 2'd3) begin
            fin_d = 1'b1; state_d = ST_MUL;
          end else begin
            e_d = e_q + 2'd1; state_d = ST_EDGE;
          end
        end
      end
      ST_SQMUL: state_d = ST_SQLOAD;
      ST_SQLOAD: begin
        v_d   = pa_q[SQ_W-1:0] + pb_q[SQ_W-1:0];
        r_d   = '0;
        bit_d = SQ_BIT_TOP;
        state_d = ST_SQRUN;
      end
      ST_SQRUN: begin
        if (sq_ge) v_d = v_q - sq_t;
        r_d   = r_next;
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          len_d[l_q] = r_next[LEN_W-1:0];
          if (l_q == 3'd4) begin
            cand_d = 2'd0; found_d = 1'b0; state_d = ST_CAND;
          end else begin
            l_d = l_q + 3'd1; state_d = ST_SQMUL;
          end
        end
      end
      ST_CAND: begin
        // ties keep the earlier route
        if (cand_take) begin
          found_d = 1'b1; best_d = cand_sum; rcnt_d = cand_cnt; r0_d = cand_r0;
        end
        if (cand_q == 2'd3) begin
          if (!cand_take && !found_q) begin
            blk_d = 1'b1; rcnt_d = 2'd0;
          end
          k_d = 2'd0;
          state_d = ST_EMIT;
        end else begin
          cand_d = cand_q + 2'd1;
        end
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          if (k_q < rcnt_q) begin
            m_x_d = (k_q[0] ^ r0_q) ? wx1 : wx0;
            m_y_d = wx0;
            m_wp_d = 1'b1; m_blk_d = 1'b0; m_last_d = 1'b0;
            k_d = k_q + 2'd1;
          end else begin
            m_x_d = bx_q; m_y_d = by_q;
            m_wp_d = 1'b0; m_blk_d = blk_q; m_last_d = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Zone test finished: next zone, next segment, or move on
    if (box_done) begin
      if (!box_hit && !box_q) begin
        box_d = 1'b1; e_d = 2'd0; fin_d = 1'b0;
        t0n_d = '0; t0d_d = MUL_W'(1); t1n_d = MUL_W'(1); t1d_d = MUL_W'(1);
        state_d = ST_EDGE;
      end else begin
        seg_free = !box_hit;
        segclr_d[s_q] = seg_free;
        if ((s_q == 3'd0) && (seg_free || a_inside)) begin
          state_d = ST_EMIT;
        end else if (s_q == 3'd6) begin
          l_d = 3'd0; state_d = ST_SQMUL;
        end else begin
          s_d = s_q + 3'd1; box_d = 1'b0; e_d = 2'd0; fin_d = 1'b0;
          t0n_d = '0; t0d_d = MUL_W'(1); t1n_d = MUL_W'(1); t1d_d = MUL_W'(1);
          state_d = ST_EDGE;
        end
      end
    end
  end

  // Control state and previous point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      have_prev_q <= have_prev_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    ax_q <= ax_d; ay_q <= ay_d; bx_q <= bx_d; by_q <= by_d;
    s_q <= s_d; l_q <= l_d; box_q <= box_d; fin_q <= fin_d;
    phase_q <= phase_d; ent_q <= ent_d; e_q <= e_d;
    t0n_q <= t0n_d; t0d_q <= t0d_d; t1n_q <= t1n_d; t1d_q <= t1d_d;
    rn_q <= rn_d; rd_q <= rd_d;
    pa_q <= pa_d; pb_q <= pb_d;
    segclr_q <= segclr_d;
    v_q <= v_d; r_q <= r_d; bit_q <= bit_d;
    len_q <= len_d;
    cand_q <= cand_d; found_q <= found_d; best_q <= best_d;
    rcnt_q <= rcnt_d; r0_q <= r0_d; blk_q <= blk_d; k_q <= k_d;
    m_x_q <= m_x_d; m_y_q <= m_y_d; m_wp_q <= m_wp_d; m_blk_q <= m_blk_d;
    m_last_q <= m_last_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(TDATA_W-2*CRD_W){1'b0}}, m_y_q, m_x_q};
  assign m_axis_tuser  = {m_blk_q, m_wp_q};
  assign m_axis_tlast  = m_last_q;

endmodule

@@ design/kor_checker.sv @@
// Port-level checks for the keep-out corner detour router, bound to the top level.
`timescale 1ns / 1ps
module kor_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [kor_pkg::TDATA_W-1:0] s_axis_tdata,   // point_x, point_y
  input logic [0:0]                  s_axis_tuser,   // first_point
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [kor_pkg::TDATA_W-1:0] m_axis_tdata,   // out_x, out_y
  input logic [1:0]                  m_axis_tuser,   // is_waypoint, blocked
  input logic                        m_axis_tlast
);
  import kor_pkg::*;

  // One point at a time: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a point is in work");

  // A waypoint is never the final result of a point
  a_waypoint_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tlast)
    else $error("waypoint marked last");

  // Blocked only on the point itself
  a_blocked_on_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
    else $error("blocked flag on a waypoint");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind keep_out_corner_detour_router kor_checker u_kor_checker (.*);
